FILE: rtl/i2cm_pkg.sv
// shared types, command codes and register indexes of the i2c master byte engine
package i2cm_pkg;

	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgIdxW  = 2;

	// command codes
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_LONG_DELAY  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SHORT_DELAY = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ACK_SAMPLES = 2'd2;

	// reset values of the configuration registers
	localparam logic [15:0] LONG_DELAY_RST  = 16'd200;
	localparam logic [15:0] SHORT_DELAY_RST = 16'd100;
	localparam logic [3:0]  ACK_SAMPLES_RST = 4'd3;

	// bits in one byte
	localparam logic [3:0] BYTE_BITS = 4'd8;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] write_data;
		logic       send_ack;
		logic       sda_sample;
	} in_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_seen;
	} out_t;

	// effective settings, zero already mapped to one
	typedef struct packed {
		logic [15:0] long_dly;
		logic [15:0] short_dly;
		logic [3:0]  ack_samp;
	} cfg_t;

endpackage

FILE: rtl/i2cm_cfg.sv
// configuration registers of the i2c master byte engine
module i2cm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data,
	output i2cm_pkg::cfg_t                cfg
);

	logic [15:0] long_q;
	logic [15:0] short_q;
	logic [3:0]  samp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q  <= i2cm_pkg::LONG_DELAY_RST;
			short_q <= i2cm_pkg::SHORT_DELAY_RST;
			samp_q  <= i2cm_pkg::ACK_SAMPLES_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				i2cm_pkg::REG_LONG_DELAY:  long_q  <= cfg_data[15:0];
				i2cm_pkg::REG_SHORT_DELAY: short_q <= cfg_data[15:0];
				i2cm_pkg::REG_ACK_SAMPLES: samp_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// a zero setting acts as one
	assign cfg.long_dly  = (long_q == '0) ? 16'd1 : long_q;
	assign cfg.short_dly = (short_q == '0) ? 16'd1 : short_q;
	assign cfg.ack_samp  = (samp_q == '0) ? 4'd1 : samp_q;

endmodule

FILE: rtl/i2cm_core.sv
// bus phase sequencer: one tick of the i2c master per processed beat
module i2cm_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tick,
	input  i2cm_pkg::in_t  item,
	input  i2cm_pkg::cfg_t cfg,
	output i2cm_pkg::out_t res
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_SP_C,
		PH_WR_A, PH_WR_BIT, PH_WR_HI, PH_AK_REL, PH_AK_IN, PH_AK_POLL,
		PH_RD_LO, PH_RD_HI, PH_RA_LO, PH_RA_DAT, PH_RA_HI
	} phase_t;

	phase_t      phase_q, phase_n, enter_ph;
	logic        enter_en;
	logic [15:0] delay_q, delay_n, delay_dec;
	logic [3:0]  bits_q, bits_n, bits_inc;
	logic [7:0]  shift_q, shift_n;
	logic [3:0]  samp_q, samp_n, samp_dec;
	logic        ackc_q, ackc_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        ack_q, ack_n;
	logic [7:0]  rd_q, rd_n;
	logic        done_q, done_n;

	assign delay_dec = delay_q - 16'd1;
	assign bits_inc  = bits_q + 4'd1;
	assign samp_dec  = samp_q - 4'd1;

	always_comb begin
		phase_n  = phase_q;
		delay_n  = delay_q;
		bits_n   = bits_q;
		shift_n  = shift_q;
		samp_n   = samp_q;
		ackc_n   = ackc_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		ack_n    = ack_q;
		rd_n     = rd_q;
		done_n   = done_q;
		enter_en = 1'b0;
		enter_ph = PH_IDLE;
		if (tick) begin
			done_n = 1'b0;
			if (phase_q == PH_IDLE) begin
				case (item.command)
					i2cm_pkg::CMD_START: begin
						enter_en = 1'b1;
						enter_ph = PH_ST_A;
					end
					i2cm_pkg::CMD_STOP: begin
						enter_en = 1'b1;
						enter_ph = PH_SP_A;
					end
					i2cm_pkg::CMD_WRITE: begin
						shift_n  = item.write_data;
						bits_n   = '0;
						enter_en = 1'b1;
						enter_ph = PH_WR_A;
					end
					i2cm_pkg::CMD_READ: begin
						ackc_n   = item.send_ack;
						shift_n  = '0;
						bits_n   = '0;
						sda_n    = 1'b1;
						enter_en = 1'b1;
						enter_ph = PH_RD_LO;
					end
					default: ;
				endcase
			end else begin
				delay_n = delay_dec;
				if (delay_dec == '0) begin
					case (phase_q)
						PH_ST_A: begin
							enter_en = 1'b1;
							enter_ph = PH_ST_B;
						end
						PH_ST_B: begin
							scl_n   = 1'b0;
							phase_n = PH_IDLE;
							delay_n = '0;
							done_n  = 1'b1;
						end
						PH_SP_A: begin
							enter_en = 1'b1;
							enter_ph = PH_SP_B;
						end
						PH_SP_B: begin
							enter_en = 1'b1;
							enter_ph = PH_SP_C;
						end
						PH_WR_A, PH_WR_BIT, PH_AK_REL, PH_AK_IN, PH_RD_LO,
						PH_RA_LO, PH_RA_DAT: begin
							enter_en = 1'b1;
							case (phase_q)
								PH_WR_A:   enter_ph = PH_WR_BIT;
								PH_WR_BIT: enter_ph = PH_WR_HI;
								PH_AK_REL: enter_ph = PH_AK_IN;
								PH_AK_IN:  enter_ph = PH_AK_POLL;
								PH_RD_LO:  enter_ph = PH_RD_HI;
								PH_RA_LO:  enter_ph = PH_RA_DAT;
								default:   enter_ph = PH_RA_HI;
							endcase
						end
						PH_WR_HI: begin
							scl_n    = 1'b0;
							shift_n  = {shift_q[6:0], 1'b0};
							bits_n   = bits_inc;
							enter_en = 1'b1;
							enter_ph = (bits_inc >= i2cm_pkg::BYTE_BITS) ? PH_AK_REL : PH_WR_BIT;
						end
						PH_AK_POLL: begin
							if (!item.sda_sample) begin
								ack_n   = 1'b1;
								scl_n   = 1'b0;
								phase_n = PH_IDLE;
								delay_n = '0;
								done_n  = 1'b1;
							end else begin
								samp_n = samp_dec;
								if (samp_dec == '0) begin
									ack_n   = 1'b0;
									scl_n   = 1'b0;
									phase_n = PH_IDLE;
									delay_n = '0;
									done_n  = 1'b1;
								end else begin
									delay_n = cfg.short_dly;
								end
							end
						end
						PH_RD_HI: begin
							shift_n  = {shift_q[6:0], item.sda_sample};
							bits_n   = bits_inc;
							enter_en = 1'b1;
							enter_ph = (bits_inc >= i2cm_pkg::BYTE_BITS) ? PH_RA_LO : PH_RD_LO;
						end
						PH_RA_HI: begin
							scl_n   = 1'b0;
							sda_n   = 1'b1;
							rd_n    = shift_q;
							phase_n = PH_IDLE;
							delay_n = '0;
							done_n  = 1'b1;
						end
						default: begin
							// stop tail and anything unexpected end the command
							phase_n = PH_IDLE;
							delay_n = '0;
							done_n  = 1'b1;
						end
					endcase
				end
			end
			// entry action of the next phase: pins and hold time
			if (enter_en) begin
				phase_n = enter_ph;
				case (enter_ph)
					PH_ST_A: begin
						sda_n = 1'b1; scl_n = 1'b1; delay_n = cfg.long_dly;
					end
					PH_ST_B, PH_SP_A: begin
						sda_n = 1'b0; delay_n = cfg.long_dly;
					end
					PH_SP_B, PH_WR_HI, PH_RA_HI: begin
						scl_n = 1'b1; delay_n = cfg.long_dly;
					end
					PH_SP_C: begin
						sda_n = 1'b1; delay_n = cfg.long_dly;
					end
					PH_WR_A, PH_RD_LO, PH_RA_LO: begin
						scl_n = 1'b0; delay_n = cfg.long_dly;
					end
					PH_WR_BIT: begin
						sda_n = shift_n[7]; delay_n = cfg.long_dly;
					end
					PH_AK_REL: begin
						sda_n = 1'b1; delay_n = cfg.short_dly;
					end
					PH_AK_IN: begin
						delay_n = cfg.short_dly;
					end
					PH_AK_POLL: begin
						scl_n = 1'b1; samp_n = cfg.ack_samp; delay_n = cfg.short_dly;
					end
					PH_RD_HI: begin
						scl_n = 1'b1; delay_n = cfg.short_dly;
					end
					PH_RA_DAT: begin
						sda_n = ~ackc_n; delay_n = cfg.long_dly;
					end
					default: begin
						phase_n = PH_IDLE; delay_n = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			delay_q <= '0;
			bits_q  <= '0;
			shift_q <= '0;
			samp_q  <= '0;
			ackc_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			rd_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_n;
			delay_q <= delay_n;
			bits_q  <= bits_n;
			shift_q <= shift_n;
			samp_q  <= samp_n;
			ackc_q  <= ackc_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ack_q   <= ack_n;
			rd_q    <= rd_n;
			done_q  <= done_n;
		end
	end

	assign res.scl_level = scl_q;
	assign res.sda_level = sda_q;
	assign res.busy_res  = (phase_q != PH_IDLE);
	assign res.done_res  = done_q;
	assign res.read_byte = rd_q;
	assign res.ack_seen  = ack_q;

endmodule

FILE: rtl/i2c_master_byte_engine.sv
// top level of the tick-driven i2c master byte engine
// path: an accepted beat goes through the input register, then the sequencer state registers,
//   which form the result register
// throughput: one beat per cycle while the result side does not stall
// reset: arst_n clears both valid bits, sequencer goes idle with scl and sda released, settings
//   return to long 200, short 100, ack samples 3
module i2c_master_byte_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel: one beat per bus tick
	input  logic                          in_valid,
	output logic                          in_stall,
	input  i2cm_pkg::in_t                 in_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output i2cm_pkg::out_t                out_data,
	// configuration write port
	input  logic                          cfg_write,
	input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data
);

	logic           valid_s1;
	i2cm_pkg::in_t  item_s1;
	logic           out_valid_q;
	logic           tick;
	i2cm_pkg::cfg_t cfg;

	// the tick is processed when the result slot is empty or being drained
	assign tick     = valid_s1 && (!out_valid_q || !out_stall);
	// input register only blocks when it is full and cannot move on
	assign in_stall = valid_s1 && !tick;

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input stage, no reset
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// result beat valid; payload is the sequencer state itself, frozen while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	i2cm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// phase sequencer, state registers double as the result register
	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (out_data)
	);

endmodule

FILE: rtl/i2cm_checker.sv
// port-level checker for the i2c master byte engine and its bind
module i2cm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input i2cm_pkg::out_t out_data
);

	// a finished command leaves the engine idle in the same beat
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done beat shows busy");

	// input only backs up when a result is waiting
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while result side is free");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	// an accepted input beat with a free result side yields a result once it has left the input register
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> ##1 out_valid)
		else $error("accepted beat produced no result");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

FILE: tb/sv/i2cm_pin_checker.sv
// pin-level predictor and result checker for the i2c master byte engine
`timescale 1ns / 100ps

module i2cm_pin_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  i2cm_pkg::in_t                 in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  i2cm_pkg::out_t                out_data,
	input  logic                          cfg_write,
	input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data,
	output int                            errors,
	output int                            outstanding
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_START_HI, PH_START_SDA, PH_STOP_SDA, PH_STOP_SCL, PH_STOP_REL,
		PH_WR_LOW, PH_WR_BIT, PH_WR_HIGH, PH_ACK_REL, PH_ACK_WAIT, PH_ACK_POLL,
		PH_RD_LOW, PH_RD_HIGH, PH_RACK_LOW, PH_RACK_DATA, PH_RACK_HIGH
	} seq_phase_t;

	logic [15:0] long_ticks;
	logic [15:0] short_ticks;
	logic [3:0]  ack_limit;

	seq_phase_t  phase;
	logic [15:0] hold_left;
	logic [3:0]  bit_idx;
	logic [7:0]  shifter;
	logic [3:0]  polls_left;
	logic        rd_ack;
	logic        scl_q;
	logic        sda_q;
	logic        acked_q;
	logic        done_q;
	logic [7:0]  rx_byte;

	i2cm_pkg::out_t pin_levels_due[$];
	i2cm_pkg::out_t due;
	int             fail_cnt;

	function automatic logic [15:0] at_least_one(logic [15:0] v);
		return (v == '0) ? 16'd1 : v;
	endfunction

	function automatic void end_command();
		phase = PH_IDLE;
		hold_left = '0;
		done_q = 1'b1;
	endfunction

	// pins change on entry, then the hold count runs
	function automatic void enter_phase(seq_phase_t p);
		phase = p;
		case (p)
			PH_START_HI: begin
				sda_q = 1'b1;
				scl_q = 1'b1;
				hold_left = at_least_one(long_ticks);
			end
			PH_START_SDA, PH_STOP_SDA: begin
				sda_q = 1'b0;
				hold_left = at_least_one(long_ticks);
			end
			PH_STOP_SCL, PH_WR_HIGH, PH_RACK_HIGH: begin
				scl_q = 1'b1;
				hold_left = at_least_one(long_ticks);
			end
			PH_STOP_REL: begin
				sda_q = 1'b1;
				hold_left = at_least_one(long_ticks);
			end
			PH_WR_LOW, PH_RD_LOW, PH_RACK_LOW: begin
				scl_q = 1'b0;
				hold_left = at_least_one(long_ticks);
			end
			PH_WR_BIT: begin
				sda_q = shifter[7];
				hold_left = at_least_one(long_ticks);
			end
			PH_ACK_REL: begin
				sda_q = 1'b1;
				hold_left = at_least_one(short_ticks);
			end
			PH_ACK_WAIT: hold_left = at_least_one(short_ticks);
			PH_ACK_POLL: begin
				scl_q = 1'b1;
				polls_left = (ack_limit == '0) ? 4'd1 : ack_limit;
				hold_left = at_least_one(short_ticks);
			end
			PH_RD_HIGH: begin
				scl_q = 1'b1;
				hold_left = at_least_one(short_ticks);
			end
			PH_RACK_DATA: begin
				sda_q = !rd_ack;
				hold_left = at_least_one(long_ticks);
			end
			default: begin
				phase = PH_IDLE;
				hold_left = '0;
			end
		endcase
	endfunction

	function automatic void phase_done(logic sda_in);
		case (phase)
			PH_START_HI:  enter_phase(PH_START_SDA);
			PH_START_SDA: begin
				scl_q = 1'b0;
				end_command();
			end
			PH_STOP_SDA:  enter_phase(PH_STOP_SCL);
			PH_STOP_SCL:  enter_phase(PH_STOP_REL);
			PH_STOP_REL:  end_command();
			PH_WR_LOW:    enter_phase(PH_WR_BIT);
			PH_WR_BIT:    enter_phase(PH_WR_HIGH);
			PH_WR_HIGH: begin
				scl_q = 1'b0;
				shifter = shifter << 1;
				bit_idx = bit_idx + 4'd1;
				if (bit_idx >= i2cm_pkg::BYTE_BITS) enter_phase(PH_ACK_REL);
				else enter_phase(PH_WR_BIT);
			end
			PH_ACK_REL:   enter_phase(PH_ACK_WAIT);
			PH_ACK_WAIT:  enter_phase(PH_ACK_POLL);
			PH_ACK_POLL: begin
				if (!sda_in) begin
					acked_q = 1'b1;
					scl_q = 1'b0;
					end_command();
				end else begin
					polls_left = polls_left - 4'd1;
					if (polls_left == '0) begin
						acked_q = 1'b0;
						scl_q = 1'b0;
						end_command();
					end else begin
						hold_left = at_least_one(short_ticks);
					end
				end
			end
			PH_RD_LOW:    enter_phase(PH_RD_HIGH);
			PH_RD_HIGH: begin
				shifter = {shifter[6:0], sda_in};
				bit_idx = bit_idx + 4'd1;
				if (bit_idx >= i2cm_pkg::BYTE_BITS) enter_phase(PH_RACK_LOW);
				else enter_phase(PH_RD_LOW);
			end
			PH_RACK_LOW:  enter_phase(PH_RACK_DATA);
			PH_RACK_DATA: enter_phase(PH_RACK_HIGH);
			PH_RACK_HIGH: begin
				scl_q = 1'b0;
				sda_q = 1'b1;
				rx_byte = shifter;
				end_command();
			end
			default:      end_command();
		endcase
	endfunction

	function automatic i2cm_pkg::out_t next_pin_levels(i2cm_pkg::in_t b);
		i2cm_pkg::out_t r;
		done_q = 1'b0;
		if (phase == PH_IDLE) begin
			case (b.command)
				i2cm_pkg::CMD_START: enter_phase(PH_START_HI);
				i2cm_pkg::CMD_STOP:  enter_phase(PH_STOP_SDA);
				i2cm_pkg::CMD_WRITE: begin
					shifter = b.write_data;
					bit_idx = '0;
					enter_phase(PH_WR_LOW);
				end
				i2cm_pkg::CMD_READ: begin
					rd_ack = b.send_ack;
					shifter = '0;
					bit_idx = '0;
					sda_q = 1'b1;
					enter_phase(PH_RD_LOW);
				end
				default: ;
			endcase
		end else begin
			hold_left = hold_left - 16'd1;
			if (hold_left == '0) phase_done(b.sda_sample);
		end
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.busy_res  = (phase != PH_IDLE);
		r.done_res  = done_q;
		r.read_byte = rx_byte;
		r.ack_seen  = acked_q;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks  = i2cm_pkg::LONG_DELAY_RST;
			short_ticks = i2cm_pkg::SHORT_DELAY_RST;
			ack_limit   = i2cm_pkg::ACK_SAMPLES_RST;
			phase       = PH_IDLE;
			hold_left   = '0;
			bit_idx     = '0;
			shifter     = '0;
			polls_left  = '0;
			rd_ack      = 1'b0;
			scl_q       = 1'b1;
			sda_q       = 1'b1;
			acked_q     = 1'b0;
			done_q      = 1'b0;
			rx_byte     = '0;
			pin_levels_due.delete();
			fail_cnt = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					i2cm_pkg::REG_LONG_DELAY:  long_ticks = cfg_data;
					i2cm_pkg::REG_SHORT_DELAY: short_ticks = cfg_data;
					i2cm_pkg::REG_ACK_SAMPLES: ack_limit = cfg_data[3:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pin_levels_due.size() == 0) begin
					$error("result beat with no pending expectation: %0h", out_data);
					fail_cnt++;
				end else begin
					due = pin_levels_due.pop_front();
					check_field("scl_level", 8'(due.scl_level), 8'(out_data.scl_level));
					check_field("sda_level", 8'(due.sda_level), 8'(out_data.sda_level));
					check_field("busy_res", 8'(due.busy_res), 8'(out_data.busy_res));
					check_field("done_res", 8'(due.done_res), 8'(out_data.done_res));
					check_field("read_byte", due.read_byte, out_data.read_byte);
					check_field("ack_seen", 8'(due.ack_seen), 8'(out_data.ack_seen));
				end
			end
			if (in_valid && !in_stall) pin_levels_due.push_back(next_pin_levels(in_data));
			errors <= fail_cnt;
			outstanding <= pin_levels_due.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// top of the i2c master byte engine bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;

	// index with no register behind it, writes must be ignored
	localparam logic [i2cm_pkg::CfgIdxW-1:0] REG_UNUSED = 2'd3;
	// command codes the block does not know
	localparam logic [2:0] CMD_RSVD_5 = 3'd5;
	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;

	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_BEATS   = 70;
	localparam int unsigned LIMIT_NS = 2_000_000;

	// how the sampled sda line behaves during a command
	typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} sda_drive_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	i2cm_pkg::in_t                 in_data;
	logic                          out_valid;
	logic                          out_stall;
	i2cm_pkg::out_t                out_data;
	logic                          cfg_write;
	logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index;
	logic [i2cm_pkg::CfgDataW-1:0] cfg_data;
	int                            errors;
	int                            outstanding;

	// settings as the block applies them, zero already mapped to one
	int   long_eff;
	int   short_eff;
	int   samples_eff;

	int   beats_sent = 0;
	int   results_seen = 0;
	int   cmds_issued = 0;
	int   settings_used = 0;
	int   burst_left = 0;
	logic no_idle = 1'b0;
	logic last_busy = 1'b0;
	int   hold_requests = 0;
	int   holds_done = 0;
	int   rx_mode;
	int   rx_mode_left = 0;
	int   hold_i;
	logic stall_next;
	int   ph;
	int   t;
	int   pick;
	int   start_beat;

	i2c_master_byte_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	i2cm_pin_checker u_pin_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// last accepted result tells whether the sequencer is still busy
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			last_busy <= out_data.busy_res;
		end
	end

	// receiver: stall pattern picks a new random mode each time the current one runs out,
	// a requested hold-off keeps the output blocked so the pipe fills up
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				for (hold_i = 0; hold_i < HOLD_CYCLES; hold_i++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(20, 200);
			end
			rx_mode_left--;
			case (rx_mode)
				0:       stall_next = 1'b0;
				1:       stall_next = ($urandom_range(0, 3) == 0);
				2:       stall_next = ($urandom_range(0, 3) != 0);
				default: stall_next = ((rx_mode_left % 8) < 3);
			endcase
			// full-rate runs never stall
			out_stall <= stall_next && !no_idle;
		end
	end

	// one beat, preceded by a random gap when a new burst starts
	task send_beat(input i2cm_pkg::in_t b);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		if (no_idle) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		burst_left--;
		beats_sent++;
	endtask

	function automatic i2cm_pkg::in_t tick_beat(logic [2:0] cmd, sda_drive_t drv);
		i2cm_pkg::in_t b;
		b.command    = cmd;
		b.write_data = 8'($urandom);
		b.send_ack   = 1'($urandom);
		case (drv)
			SDA_LOW:  b.sda_sample = 1'b0;
			SDA_HIGH: b.sda_sample = 1'b1;
			default:  b.sda_sample = 1'($urandom);
		endcase
		return b;
	endfunction

	// a command followed by enough ticks to finish it; stray commands only
	// land while the block is surely busy, so they are all ignored
	task run_cmd(input logic [2:0] cmd, input logic [7:0] data, input logic ack,
			input sda_drive_t drv);
		int lo;
		int hi;
		int k;
		i2cm_pkg::in_t b;
		case (cmd)
			i2cm_pkg::CMD_START: lo = 2 * long_eff;
			i2cm_pkg::CMD_STOP:  lo = 3 * long_eff;
			i2cm_pkg::CMD_WRITE: lo = 17 * long_eff + 3 * short_eff;
			i2cm_pkg::CMD_READ:  lo = 8 * (long_eff + short_eff) + 3 * long_eff;
			default:             lo = 0;
		endcase
		// a write may poll for the ack up to the full sample count
		hi = (cmd == i2cm_pkg::CMD_WRITE && drv != SDA_LOW) ?
			lo + (samples_eff - 1) * short_eff : lo;
		b = tick_beat(cmd, drv);
		b.write_data = data;
		b.send_ack = ack;
		send_beat(b);
		cmds_issued++;
		for (k = 1; k <= hi; k++) begin
			b = tick_beat(i2cm_pkg::CMD_NONE, drv);
			if (k <= lo && !no_idle && $urandom_range(0, 9) == 0) b.command = 3'($urandom);
			send_beat(b);
		end
		if (!no_idle) repeat ($urandom_range(0, 2)) send_beat(tick_beat(i2cm_pkg::CMD_NONE, drv));
	endtask

	// stop offering and wait until every result is back
	task drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// drained and sequencer idle: safe for register writes
	task settle();
		drain();
		while (last_busy) begin
			send_beat(tick_beat(i2cm_pkg::CMD_NONE, SDA_RAND));
			drain();
		end
	endtask

	task write_reg(input logic [i2cm_pkg::CfgIdxW-1:0] idx,
			input logic [i2cm_pkg::CfgDataW-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task set_regs(input logic [15:0] l, input logic [15:0] s, input logic [3:0] n);
		write_reg(i2cm_pkg::REG_LONG_DELAY, l);
		write_reg(i2cm_pkg::REG_SHORT_DELAY, s);
		write_reg(i2cm_pkg::REG_ACK_SAMPLES, 16'(n));
		cfg_write <= 1'b0;
		long_eff = (l == '0) ? 1 : int'(l);
		short_eff = (s == '0) ? 1 : int'(s);
		samples_eff = (n == '0) ? 1 : int'(n);
		settings_used++;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		long_eff = int'(i2cm_pkg::LONG_DELAY_RST);
		short_eff = int'(i2cm_pkg::SHORT_DELAY_RST);
		samples_eff = int'(i2cm_pkg::ACK_SAMPLES_RST);
		settings_used = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: a start at the default long delay
		run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, SDA_RAND);

		// zero delays and zero sample count behave as one, index 3 goes nowhere
		settle();
		write_reg(REG_UNUSED, 16'hFFFF);
		set_regs(16'd0, 16'd0, 4'd0);
		run_cmd(i2cm_pkg::CMD_NONE, 8'hFF, 1'b1, SDA_RAND);
		run_cmd(CMD_RSVD_5, 8'h00, 1'b0, SDA_RAND);
		run_cmd(CMD_RSVD_6, 8'hFF, 1'b1, SDA_RAND);
		run_cmd(CMD_RSVD_7, 8'h00, 1'b0, SDA_RAND);
		run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, SDA_RAND);
		run_cmd(i2cm_pkg::CMD_WRITE, 8'h00, 1'b0, SDA_HIGH);
		run_cmd(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1, SDA_LOW);
		run_cmd(i2cm_pkg::CMD_READ, 8'h00, 1'b1, SDA_HIGH);
		run_cmd(i2cm_pkg::CMD_READ, 8'hFF, 1'b0, SDA_LOW);
		run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RAND);

		// full ack sample count, nack after fifteen high polls
		settle();
		set_regs(16'd2, 16'd3, 4'd15);
		run_cmd(i2cm_pkg::CMD_WRITE, 8'h5A, 1'b0, SDA_HIGH);
		run_cmd(i2cm_pkg::CMD_WRITE, 8'h81, 1'b1, SDA_RAND);
		run_cmd(i2cm_pkg::CMD_READ, 8'h3C, 1'b1, SDA_RAND);
		// stop offered on the very tick the start finishes, must be dropped
		send_beat(tick_beat(i2cm_pkg::CMD_START, SDA_RAND));
		cmds_issued++;
		for (t = 1; t < 2 * long_eff; t++) send_beat(tick_beat(i2cm_pkg::CMD_NONE, SDA_RAND));
		send_beat(tick_beat(i2cm_pkg::CMD_STOP, SDA_RAND));
		run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RAND);

		// back to back at full rate: a start on long delays, a write on long delay 1 and short delay 20
		settle();
		set_regs(16'd40, 16'd1, 4'd15);
		no_idle = 1'b1;
		run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, SDA_RAND);
		settle();
		set_regs(16'd1, 16'd20, 4'd15);
		run_cmd(i2cm_pkg::CMD_WRITE, 8'hC3, 1'b0, SDA_LOW);
		settle();
		no_idle = 1'b0;

		// random part: mostly whole commands with random content, some raw noise
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			set_regs(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
				(ph == RANDOM_PHASES - 1) ? 4'd15 : 4'($urandom_range(0, 6)));
			// output blocked for a long stretch while beats keep coming
			if (ph == 1) hold_requests++;
			start_beat = beats_sent;
			while (beats_sent - start_beat < PHASE_BEATS) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					drain();
				end else if (pick < 4) begin
					repeat ($urandom_range(1, 6)) send_beat(tick_beat(3'($urandom), SDA_RAND));
				end else begin
					case ($urandom_range(0, 3))
						0: run_cmd(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom), SDA_RAND);
						1: run_cmd(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND);
						2: run_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RAND);
						default: run_cmd(i2cm_pkg::CMD_READ, 8'($urandom), 1'($urandom), SDA_RAND);
					endcase
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d input beats and %0d bus commands over %0d register settings",
			beats_sent, cmds_issued, settings_used);
		$display("checked %0d result beats, incl. full-rate runs and a %0d-cycle hold-off",
			results_seen, HOLD_CYCLES);
		if (errors == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#LIMIT_NS;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sim.f
rtl/i2cm_pkg.sv
rtl/i2cm_cfg.sv
rtl/i2cm_core.sv
rtl/i2c_master_byte_engine.sv
rtl/i2cm_checker.sv
tb/sv/i2cm_pin_checker.sv
tb/sv/testbench.sv
